### rtl/tmcg_pkg.sv
// tmcg_pkg: shared types, codes and the 8x16 font table of the text-mode
// character generator
// depends on nothing; imported by every module of the block
package tmcg_pkg;

  // input opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // character codes
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] GLYPH_LAST     = 8'h5f;
  localparam logic [6:0] GLYPH_FALLBACK = 7'(8'h3f - 8'h20);

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_kind_t;

  // classified item travelling from front to back
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] code;
    logic       blank;
    logic       half;
    logic [2:0] gcol;
  } cmd_t;

  // one glyph per entry: {lower 4..7, lower 0..3, upper 4..7, upper 0..3},
  // one byte per pixel column, bit 0 top
  localparam logic [127:0] GLYPH_ROM [96] = '{
    128'h00000000_00000000_00000000_00000000,
    128'h0000000d_0d000000_000038fc_fc380000,
    128'h00000000_00000000_000e1e00_001e0e00,
    128'h00020f0f_020f0f02_0020f8f8_20f8f820,
    128'h00070f38_38080c06_0098cc47_47447c38,
    128'h000c0c00_0103060c_003060c0_80003030,
    128'h00080f07_08080f07_0040d8bc_e47cd880,
    128'h00000000_00000000_00000000_0e1e1000,
    128'h0000080c_07030000_0000040c_f8f00000,
    128'h00000307_0c080000_0000f0f8_0c040000,
    128'h00020301_01030200_80a0e0c0_c0e0a080,
    128'h00000003_03000000_008080e0_e0808000,
    128'h0000000e_1e100000_00000000_00000000,
    128'h00000000_00000000_00808080_80808080,
    128'h0000000c_0c000000_00000000_00000000,
    128'h00000000_0103060c_003060c0_80000000,
    128'h0003070c_080c0703_00f0f80c_c40cf8f0,
    128'h0008080f_0f080800_000000fc_fc181000,
    128'h000c0c08_08090f0e_00183c64_c4840c08,
    128'h00070f08_08080c04_00b8fc44_44440c08,
    128'h00080f0f_08000000_0080fcfc_98b0e0c0,
    128'h00070f08_08080c04_0084c444_44447c7c,
    128'h00070f08_08080f07_0080c044_444cf8f0,
    128'h00000000_0f0f0000_003c7cc4_84040c0c,
    128'h00070f08_08080f07_00b8fc44_4444fcb8,
    128'h0003070c_08080800_00f8fc44_44447c38,
    128'h00000006_06000000_00000030_30000000,
    128'h00000006_0e080000_00000030_30000000,
    128'h00080c06_03010000_00081830_60c08000,
    128'h00010101_01010100_00202020_20202000,
    128'h00000103_060c0800_0080c060_30180800,
    128'h0000000d_0d000000_00183ce4_c4041c18,
    128'h00010b0b_0b080f07_00f0f8c8_c808f8f0,
    128'h000f0f00_00000f0f_00e0f098_8c98f0e0,
    128'h00070f08_080f0f08_00b8fc44_44fcfc04,
    128'h00060c08_080c0703_00180c04_040cf8f0,
    128'h0003070c_080f0f08_00f0f80c_04fcfc04,
    128'h000e0c08_080f0f08_001c0ce4_44fcfc04,
    128'h00000000_080f0f08_001c0ce4_44fcfc04,
    128'h000f0708_080c0703_00988c84_840cf8f0,
    128'h000f0f00_00000f0f_00fcfc40_4040fcfc,
    128'h0000080f_0f080000_000004fc_fc040000,
    128'h0000070f_08080f07_0004fcfc_04000000,
    128'h000e0f01_000f0f08_001c3ce0_c0fcfc04,
    128'h000e0c08_080f0f08_00000000_04fcfc04,
    128'h000f0f00_00000f0f_00fcfc38_7038fcfc,
    128'h000f0f00_00000f0f_00fcfce0_7038fcfc,
    128'h00070f08_08080f07_00f8fc04_0404fcf8,
    128'h00000000_080f0f08_00387c44_44fcfc04,
    128'h00273f3c_0e080f07_00f8fc04_0404fcf8,
    128'h000f0f00_000f0f08_0038fcc4_44fcfc04,
    128'h00070f08_08080e06_00189cc4_44643c18,
    128'h0000080f_0f080000_001c0cfc_fc0c1c00,
    128'h00070f08_08080f07_00fcfc00_0000fcfc,
    128'h00010306_0c060301_00fcfc00_0000fcfc,
    128'h00070f0e_030e0f07_00fcfc00_c000fcfc,
    128'h000c0f03_01030f0c_000c3cf0_e0f03c0c,
    128'h0000080f_0f080000_003c7cc0_c07c3c00,
    128'h000e0c08_08090f0e_001c3c64_c4840c1c,
    128'h00000808_0f0f0000_00000404_fcfc0000,
    128'h000e0703_01000000_00000080_c0e07038,
    128'h00000f0f_08080000_0000fcfc_04040000,
    128'h00000000_00000000_00080c06_03060c08,
    128'h20202020_20202020_00000000_00000000,
    128'h00000000_00000000_0000080c_06020000,
    128'h00080f07_08080f07_0000c0e0_a0a0a000,
    128'h00070f08_080f0f00_0080c060_20fcfc04,
    128'h00040c08_08080f07_00406020_2020e0c0,
    128'h00080f07_08080f07_0000fcfc_2460c080,
    128'h00040c08_08080f07_00c0e0a0_a0a0e0c0,
    128'h00000008_0f0f0800_00180c44_fcf84000,
    128'h00003f7f_48486f27_0020e0c0_2020e0c0,
    128'h000f0f00_000f0f08_00c0e020_40fcfc04,
    128'h0000080f_0f080000_000000ec_ec200000,
    128'h003f7f40_40703000_00ecec20_00000000,
    128'h000c0e03_010f0f08_002060c0_80fcfc04,
    128'h0000080f_0f080000_000000fc_fc040000,
    128'h000f0f00_07000f0f_00c0e060_c060e0e0,
    128'h000f0f00_000f0f00_00c0e020_20c0e020,
    128'h00070f08_08080f07_00c0e020_2020e0c0,
    128'h00070f08_487f7f40_00c0e020_20c0e020,
    128'h00407f7f_48080f07_0020e0c0_2020e0c0,
    128'h00000000_080f0f08_00c0e020_60c0e020,
    128'h00040e0b_09090c04_00406020_20a0e040,
    128'h00040c08_0f070000_00002020_fcf82020,
    128'h00080f07_08080f07_0000e0e0_0000e0e0,
    128'h0003070c_080c0703_00e0e000_0000e0e0,
    128'h00070f0c_070c0f07_00e0e000_8000e0e0,
    128'h00080c07_03070c08_002060c0_80c06020,
    128'h001f3f68_48484f47_00e0e000_0000e0e0,
    128'h000c0c08_090b0e0c_002060e0_a0206060,
    128'h0008080f_07000000_000404bc_f8404000,
    128'h0000000f_0f000000_000000fc_fc000000,
    128'h00000007_0f080800_004040f8_bc040400,
    128'h00000000_00000000_00020604_06020604,
    128'h00070704_04040707_0080c060_3060c080
  };

  // glyph offset of a raw code, out-of-font codes map to '?'
  function automatic logic [6:0] glyph_index(logic [7:0] code);
    logic [7:0] off;
    off = code - CHAR_SPACE;
    if (off > GLYPH_LAST) begin
      return GLYPH_FALLBACK;
    end
    return off[6:0];
  endfunction

  // one column byte of a glyph; sel = {half, glyph column}
  function automatic logic [7:0] glyph_byte(logic [6:0] glyph, logic [3:0] sel);
    logic [127:0] bits;
    bits = GLYPH_ROM[glyph];
    return bits[{sel, 3'b000} +: 8];
  endfunction

endpackage

### rtl/tmcg_front.sv
// tmcg_front: decodes input items into write, clear and read commands
// and works out the text store index
// depends on tmcg_pkg
module tmcg_front #(
  parameter int TEXT_COLUMNS = 16,
  parameter int TEXT_ROWS    = 2,
  parameter int IDX_W        = 5
) (
  input  logic             in_valid,
  input  logic [1:0]       opcode,
  input  logic             row,
  input  logic [4:0]       col,
  input  logic [7:0]       char_code,
  input  logic [8:0]       byte_address,
  output logic             push,
  output tmcg_pkg::cmd_t   cmd,
  output logic [IDX_W-1:0] idx
);
  import tmcg_pkg::*;

  logic       rd_trow;
  logic [3:0] rd_chr;
  logic       wr_ok;
  logic       rd_blank;

  assign rd_trow  = byte_address[8];
  assign rd_chr   = byte_address[6:3];
  assign wr_ok    = (int'(row) < TEXT_ROWS) && (int'(col) < TEXT_COLUMNS);
  assign rd_blank = (int'(rd_trow) >= TEXT_ROWS) || (int'(rd_chr) >= TEXT_COLUMNS);

  always_comb begin
    push       = 1'b0;
    idx        = '0;
    cmd.kind   = CMD_CLEAR;
    cmd.code   = char_code;
    cmd.blank  = rd_blank;
    cmd.half   = byte_address[7];
    cmd.gcol   = byte_address[2:0];
    unique case (opcode)
      OP_WRITE: begin
        cmd.kind = CMD_WRITE;
        push     = in_valid && wr_ok;
        if (wr_ok) begin
          idx = IDX_W'(int'(row) * TEXT_COLUMNS + int'(col));
        end
      end
      OP_CLEAR: begin
        cmd.kind = CMD_CLEAR;
        push     = in_valid;
      end
      OP_READ: begin
        cmd.kind = CMD_READ;
        push     = in_valid;
        if (!rd_blank) begin
          idx = IDX_W'(int'(rd_trow) * TEXT_COLUMNS + int'(rd_chr));
        end
      end
      default: begin
        // unknown opcode: item taken, nothing to do
        push = 1'b0;
      end
    endcase
  end

endmodule

### rtl/tmcg_queue.sv
// tmcg_queue: two-entry command queue between front and back
// depends on tmcg_pkg
module tmcg_queue #(
  parameter int IDX_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tmcg_pkg::cmd_t   push_cmd,
  input  logic [IDX_W-1:0] push_idx,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output tmcg_pkg::cmd_t   q_cmd,
  output logic [IDX_W-1:0] q_idx
);
  import tmcg_pkg::*;

  cmd_t             slot_cmd [2];
  logic [IDX_W-1:0] slot_idx [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;
  assign q_cmd   = slot_cmd[rd_ptr];
  assign q_idx   = slot_idx[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_cmd[wr_ptr] <= push_cmd;
      slot_idx[wr_ptr] <= push_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

### rtl/tmcg_back.sv
// tmcg_back: text store, per-entry fill flags, glyph lookup and result register
// depends on tmcg_pkg
module tmcg_back #(
  parameter int DEPTH = 32,
  parameter int IDX_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  tmcg_pkg::cmd_t   q_cmd,
  input  logic [IDX_W-1:0] q_idx,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       bitmap_byte
);
  import tmcg_pkg::*;

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] filled;
  logic [7:0]       rd_data;
  logic             s1_valid;
  logic             s1_filled;
  logic             s1_blank;
  logic             s1_half;
  logic [2:0]       s1_gcol;
  logic             s1_move;
  logic             s1_free;
  logic             do_write;
  logic             do_clear;
  logic             do_read;
  logic [7:0]       shown_code;
  logic [7:0]       render;

  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign s1_free  = !s1_valid || s1_move;
  assign pop      = q_valid && ((q_cmd.kind != CMD_READ) || s1_free);
  assign do_write = pop && (q_cmd.kind == CMD_WRITE);
  assign do_clear = pop && (q_cmd.kind == CMD_CLEAR);
  assign do_read  = pop && (q_cmd.kind == CMD_READ);

  // never-written or cleared entries read as space
  assign shown_code = s1_filled ? rd_data : CHAR_SPACE;
  assign render     = s1_blank ? 8'h00
                    : glyph_byte(glyph_index(shown_code), {s1_half, s1_gcol});

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[q_idx] <= q_cmd.code;
    end
    if (do_read) begin
      rd_data <= mem[q_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      filled <= '0;
    end else if (do_write) begin
      filled[q_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      s1_filled <= filled[q_idx];
      s1_blank  <= q_cmd.blank;
      s1_half   <= q_cmd.half;
      s1_gcol   <= q_cmd.gcol;
    end
    if (s1_move) begin
      bitmap_byte <= render;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (do_read) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/text_mode_character_generator_core.sv
// text_mode_character_generator_core: top level of the text-mode character
// generator; front decoder, command queue and render back end
// depends on tmcg_pkg, tmcg_front, tmcg_queue, tmcg_back
//
// input channel (in_valid/in_ready): opcode, row, col, char_code, byte_address
//   write puts char_code at row/col (out-of-range places are dropped), clear
//   sets every cell back to space, read asks for one bitmap byte
// output channel (out_valid/out_ready): bitmap_byte, one per read item only
// read path: a queue entry, then the store read into the lookup stage, then the result register
// throughput: one item per cycle sustained while out_ready holds; the back end
//   retires one queued command per cycle, the single-port text store one access a cycle
// reset: queue and pipeline empty, all fill flags cleared, so every cell
//   reads as space right away
// receiver stall: the result register holds, one more read waits in the
//   lookup stage, then the two-entry queue fills and in_ready drops;
//   writes and clears queued ahead of the next read keep draining while
//   the lookup stage waits
module text_mode_character_generator_core #(
  parameter int TEXT_COLUMNS = 16,
  parameter int TEXT_ROWS    = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  input  logic       row,
  input  logic [4:0] col,
  input  logic [7:0] char_code,
  input  logic [8:0] byte_address,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] bitmap_byte
);
  import tmcg_pkg::*;

  // store size follows the text geometry
  localparam int DEPTH = TEXT_ROWS * TEXT_COLUMNS;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic             push;
  cmd_t             push_cmd;
  logic [IDX_W-1:0] push_idx;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  cmd_t             q_cmd;
  logic [IDX_W-1:0] q_idx;

  // items are taken whenever the queue has room; dropped items take no entry
  assign in_ready = !q_full;

  tmcg_front #(
    .TEXT_COLUMNS(TEXT_COLUMNS),
    .TEXT_ROWS   (TEXT_ROWS),
    .IDX_W       (IDX_W)
  ) u_front (
    .in_valid    (in_valid && in_ready),
    .opcode      (opcode),
    .row         (row),
    .col         (col),
    .char_code   (char_code),
    .byte_address(byte_address),
    .push        (push),
    .cmd         (push_cmd),
    .idx         (push_idx)
  );

  tmcg_queue #(
    .IDX_W(IDX_W)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .push_idx(push_idx),
    .full    (q_full),
    .pop     (q_pop),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_idx   (q_idx)
  );

  // back end: registered store access, glyph lookup into the result register
  tmcg_back #(
    .DEPTH(DEPTH),
    .IDX_W(IDX_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_idx      (q_idx),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .bitmap_byte(bitmap_byte)
  );

  // a command is never pushed into a full queue
  assert property (@(posedge clk) disable iff (rst) !(push && q_full))
    else $error("command pushed into full queue");

  // the back end only retires commands that are present
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");

  // reset leaves the queue and the result register empty
  assert property (@(posedge clk) disable iff (rst)
                   $past(rst) |-> (!q_valid && !out_valid))
    else $error("state not cleared by reset");

endmodule

### tb/tb_text_mode_character_generator_core.sv
// testbench for text_mode_character_generator_core: writes, clears and bitmap
// reads checked against a local store and 8x16 font, with random idling
// depends on tmcg_pkg and text_mode_character_generator_core
`timescale 1ns / 100ps

module tb_text_mode_character_generator_core;
  import tmcg_pkg::*;

  localparam int COLS = 16;
  localparam int ROWS = 2;
  localparam logic [1:0] OP_NONE = 2'd3;   // undefined opcode, no effect
  localparam logic [7:0] FIRST_CODE = 8'h20;
  localparam logic [7:0] LAST_OFFSET = 8'h5f;
  localparam logic [7:0] FALLBACK_GLYPH = 8'h3f - 8'h20;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD = 150;
  localparam int DRAIN_CYCLES = 8;

  // per glyph: upper half two words, lower half two words; low byte is the
  // leftmost pixel column
  localparam logic [31:0] FONT_WORDS [384] = '{
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'hfc380000, 32'h000038fc, 32'h0d000000, 32'h0000000d,
    32'h001e0e00, 32'h000e1e00, 32'h00000000, 32'h00000000,
    32'h20f8f820, 32'h0020f8f8, 32'h020f0f02, 32'h00020f0f,
    32'h47447c38, 32'h0098cc47, 32'h38080c06, 32'h00070f38,
    32'h80003030, 32'h003060c0, 32'h0103060c, 32'h000c0c00,
    32'he47cd880, 32'h0040d8bc, 32'h08080f07, 32'h00080f07,
    32'h0e1e1000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'hf8f00000, 32'h0000040c, 32'h07030000, 32'h0000080c,
    32'h0c040000, 32'h0000f0f8, 32'h0c080000, 32'h00000307,
    32'hc0e0a080, 32'h80a0e0c0, 32'h01030200, 32'h00020301,
    32'he0808000, 32'h008080e0, 32'h03000000, 32'h00000003,
    32'h00000000, 32'h00000000, 32'h1e100000, 32'h0000000e,
    32'h80808080, 32'h00808080, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h0c000000, 32'h0000000c,
    32'h80000000, 32'h003060c0, 32'h0103060c, 32'h00000000,
    32'hc40cf8f0, 32'h00f0f80c, 32'h080c0703, 32'h0003070c,
    32'hfc181000, 32'h000000fc, 32'h0f080800, 32'h0008080f,
    32'hc4840c08, 32'h00183c64, 32'h08090f0e, 32'h000c0c08,
    32'h44440c08, 32'h00b8fc44, 32'h08080c04, 32'h00070f08,
    32'h98b0e0c0, 32'h0080fcfc, 32'h08000000, 32'h00080f0f,
    32'h44447c7c, 32'h0084c444, 32'h08080c04, 32'h00070f08,
    32'h444cf8f0, 32'h0080c044, 32'h08080f07, 32'h00070f08,
    32'h84040c0c, 32'h003c7cc4, 32'h0f0f0000, 32'h00000000,
    32'h4444fcb8, 32'h00b8fc44, 32'h08080f07, 32'h00070f08,
    32'h44447c38, 32'h00f8fc44, 32'h08080800, 32'h0003070c,
    32'h30000000, 32'h00000030, 32'h06000000, 32'h00000006,
    32'h30000000, 32'h00000030, 32'h0e080000, 32'h00000006,
    32'h60c08000, 32'h00081830, 32'h03010000, 32'h00080c06,
    32'h20202000, 32'h00202020, 32'h01010100, 32'h00010101,
    32'h30180800, 32'h0080c060, 32'h060c0800, 32'h00000103,
    32'hc4041c18, 32'h00183ce4, 32'h0d000000, 32'h0000000d,
    32'hc808f8f0, 32'h00f0f8c8, 32'h0b080f07, 32'h00010b0b,
    32'h8c98f0e0, 32'h00e0f098, 32'h00000f0f, 32'h000f0f00,
    32'h44fcfc04, 32'h00b8fc44, 32'h080f0f08, 32'h00070f08,
    32'h040cf8f0, 32'h00180c04, 32'h080c0703, 32'h00060c08,
    32'h04fcfc04, 32'h00f0f80c, 32'h080f0f08, 32'h0003070c,
    32'h44fcfc04, 32'h001c0ce4, 32'h080f0f08, 32'h000e0c08,
    32'h44fcfc04, 32'h001c0ce4, 32'h080f0f08, 32'h00000000,
    32'h840cf8f0, 32'h00988c84, 32'h080c0703, 32'h000f0708,
    32'h4040fcfc, 32'h00fcfc40, 32'h00000f0f, 32'h000f0f00,
    32'hfc040000, 32'h000004fc, 32'h0f080000, 32'h0000080f,
    32'h04000000, 32'h0004fcfc, 32'h08080f07, 32'h0000070f,
    32'hc0fcfc04, 32'h001c3ce0, 32'h000f0f08, 32'h000e0f01,
    32'h04fcfc04, 32'h00000000, 32'h080f0f08, 32'h000e0c08,
    32'h7038fcfc, 32'h00fcfc38, 32'h00000f0f, 32'h000f0f00,
    32'h7038fcfc, 32'h00fcfce0, 32'h00000f0f, 32'h000f0f00,
    32'h0404fcf8, 32'h00f8fc04, 32'h08080f07, 32'h00070f08,
    32'h44fcfc04, 32'h00387c44, 32'h080f0f08, 32'h00000000,
    32'h0404fcf8, 32'h00f8fc04, 32'h0e080f07, 32'h00273f3c,
    32'h44fcfc04, 32'h0038fcc4, 32'h000f0f08, 32'h000f0f00,
    32'h44643c18, 32'h00189cc4, 32'h08080e06, 32'h00070f08,
    32'hfc0c1c00, 32'h001c0cfc, 32'h0f080000, 32'h0000080f,
    32'h0000fcfc, 32'h00fcfc00, 32'h08080f07, 32'h00070f08,
    32'h0000fcfc, 32'h00fcfc00, 32'h0c060301, 32'h00010306,
    32'hc000fcfc, 32'h00fcfc00, 32'h030e0f07, 32'h00070f0e,
    32'he0f03c0c, 32'h000c3cf0, 32'h01030f0c, 32'h000c0f03,
    32'hc07c3c00, 32'h003c7cc0, 32'h0f080000, 32'h0000080f,
    32'hc4840c1c, 32'h001c3c64, 32'h08090f0e, 32'h000e0c08,
    32'hfcfc0000, 32'h00000404, 32'h0f0f0000, 32'h00000808,
    32'hc0e07038, 32'h00000080, 32'h01000000, 32'h000e0703,
    32'h04040000, 32'h0000fcfc, 32'h08080000, 32'h00000f0f,
    32'h03060c08, 32'h00080c06, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h20202020, 32'h20202020,
    32'h06020000, 32'h0000080c, 32'h00000000, 32'h00000000,
    32'ha0a0a000, 32'h0000c0e0, 32'h08080f07, 32'h00080f07,
    32'h20fcfc04, 32'h0080c060, 32'h080f0f00, 32'h00070f08,
    32'h2020e0c0, 32'h00406020, 32'h08080f07, 32'h00040c08,
    32'h2460c080, 32'h0000fcfc, 32'h08080f07, 32'h00080f07,
    32'ha0a0e0c0, 32'h00c0e0a0, 32'h08080f07, 32'h00040c08,
    32'hfcf84000, 32'h00180c44, 32'h0f0f0800, 32'h00000008,
    32'h2020e0c0, 32'h0020e0c0, 32'h48486f27, 32'h00003f7f,
    32'h40fcfc04, 32'h00c0e020, 32'h000f0f08, 32'h000f0f00,
    32'hec200000, 32'h000000ec, 32'h0f080000, 32'h0000080f,
    32'h00000000, 32'h00ecec20, 32'h40703000, 32'h003f7f40,
    32'h80fcfc04, 32'h002060c0, 32'h010f0f08, 32'h000c0e03,
    32'hfc040000, 32'h000000fc, 32'h0f080000, 32'h0000080f,
    32'hc060e0e0, 32'h00c0e060, 32'h07000f0f, 32'h000f0f00,
    32'h20c0e020, 32'h00c0e020, 32'h000f0f00, 32'h000f0f00,
    32'h2020e0c0, 32'h00c0e020, 32'h08080f07, 32'h00070f08,
    32'h20c0e020, 32'h00c0e020, 32'h487f7f40, 32'h00070f08,
    32'h2020e0c0, 32'h0020e0c0, 32'h48080f07, 32'h00407f7f,
    32'h60c0e020, 32'h00c0e020, 32'h080f0f08, 32'h00000000,
    32'h20a0e040, 32'h00406020, 32'h09090c04, 32'h00040e0b,
    32'hfcf82020, 32'h00002020, 32'h0f070000, 32'h00040c08,
    32'h0000e0e0, 32'h0000e0e0, 32'h08080f07, 32'h00080f07,
    32'h0000e0e0, 32'h00e0e000, 32'h080c0703, 32'h0003070c,
    32'h8000e0e0, 32'h00e0e000, 32'h070c0f07, 32'h00070f0c,
    32'h80c06020, 32'h002060c0, 32'h03070c08, 32'h00080c07,
    32'h0000e0e0, 32'h00e0e000, 32'h48484f47, 32'h001f3f68,
    32'ha0206060, 32'h002060e0, 32'h090b0e0c, 32'h000c0c08,
    32'hf8404000, 32'h000404bc, 32'h07000000, 32'h0008080f,
    32'hfc000000, 32'h000000fc, 32'h0f000000, 32'h0000000f,
    32'hbc040400, 32'h004040f8, 32'h0f080800, 32'h00000007,
    32'h06020604, 32'h00020604, 32'h00000000, 32'h00000000,
    32'h3060c080, 32'h0080c060, 32'h04040707, 32'h00070704
  };

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] opcode;
  logic       row;
  logic [4:0] col;
  logic [7:0] char_code;
  logic [8:0] byte_address;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] bitmap_byte;

  logic [7:0] text_cells [ROWS*COLS];
  logic [7:0] pending_bytes [$];
  logic [7:0] want_byte;
  int         error_count = 0;
  int         idle_cycles = 0;
  int         hold_request = 0;
  bit         src_idle_on = 0;
  bit         sink_idle_on = 0;

  text_mode_character_generator_core #(
    .TEXT_COLUMNS(COLS),
    .TEXT_ROWS(ROWS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .row(row),
    .col(col),
    .char_code(char_code),
    .byte_address(byte_address),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .bitmap_byte(bitmap_byte)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void blank_cells();
    for (int k = 0; k < ROWS*COLS; k++) begin
      text_cells[k] = FIRST_CODE;
    end
  endfunction

  // one vertical byte of the page-ordered bitmap
  function automatic logic [7:0] render_column(logic [8:0] addr);
    logic [1:0]  page;
    logic [6:0]  x;
    int          trow;
    int          chr;
    logic [2:0]  gcol;
    logic [7:0]  glyph;
    logic [31:0] word;
    page = addr[8:7];
    x    = addr[6:0];
    trow = page[1];
    chr  = x[6:3];
    gcol = x[2:0];
    if (trow >= ROWS || chr >= COLS) begin
      return 8'h00;
    end
    glyph = text_cells[trow*COLS + chr] - FIRST_CODE;
    if (glyph > LAST_OFFSET) begin
      glyph = FALLBACK_GLYPH;
    end
    word = FONT_WORDS[glyph*4 + page[0]*2 + gcol[2]];
    return word[8*gcol[1:0] +: 8];
  endfunction

  // store update and expected byte for one accepted item
  function automatic void track_item(logic [1:0] op, logic r, logic [4:0] c,
                                     logic [7:0] code, logic [8:0] addr);
    case (op)
      OP_WRITE: begin
        if (r < ROWS && c < COLS) begin
          text_cells[r*COLS + c] = code;
        end
      end
      OP_CLEAR: blank_cells();
      OP_READ:  pending_bytes.push_back(render_column(addr));
      default: ;
    endcase
  endfunction

  // prediction on input items, comparison on output items
  always @(posedge clk) begin
    if (rst) begin
      blank_cells();
    end else begin
      if (in_valid && in_ready) begin
        track_item(opcode, row, col, char_code, byte_address);
      end
      if (out_valid && out_ready) begin
        if (pending_bytes.size() == 0) begin
          $error("bitmap_byte: no read waiting, actual %02h", bitmap_byte);
          error_count++;
        end else begin
          want_byte = pending_bytes.pop_front();
          if (bitmap_byte !== want_byte) begin
            $error("bitmap_byte: expected %02h, actual %02h", want_byte, bitmap_byte);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any item moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("text_mode_character_generator_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stall bursts, or one long hold when asked
  initial begin : sink_side
    int hold_n;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_n = hold_request;
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (hold_n) @(posedge clk);
        out_ready <= 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // offer one item and wait until it is taken
  task automatic send_item(logic [1:0] op, logic r, logic [4:0] c,
                           logic [7:0] code, logic [8:0] addr);
    if (src_idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    row          <= r;
    col          <= c;
    char_code    <= code;
    byte_address <= addr;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly in-range writes and reads, some clears, stray cols and opcodes
  task automatic send_random_item();
    int         pick;
    logic [1:0] op;
    logic [4:0] c;
    logic [7:0] code;
    pick = $urandom_range(0, 99);
    if (pick < 46) begin
      op = OP_WRITE;
    end else if (pick < 94) begin
      op = OP_READ;
    end else if (pick < 97) begin
      op = OP_CLEAR;
    end else begin
      op = OP_NONE;
    end
    c = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(16, 31)) : 5'($urandom_range(0, 15));
    code = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(8'h20, 8'h7f));
    send_item(op, 1'($urandom), c, code, 9'($urandom));
  endtask

  task automatic test_directed();
    send_item(OP_READ,  1'b0, 5'd0,  8'h00, 9'h000);   // space after reset
    send_item(OP_READ,  1'b1, 5'd31, 8'hff, 9'h1ff);   // last byte of the page
    send_item(OP_WRITE, 1'b0, 5'd0,  8'h00, 9'h000);   // below font, shows '?'
    send_item(OP_WRITE, 1'b0, 5'd1,  8'h7f, 9'h1ff);   // last font code
    send_item(OP_WRITE, 1'b0, 5'd2,  8'h80, 9'h000);   // just above font
    send_item(OP_WRITE, 1'b0, 5'd3,  8'hff, 9'h000);
    send_item(OP_WRITE, 1'b1, 5'd15, 8'h1f, 9'h000);
    send_item(OP_WRITE, 1'b1, 5'd16, 8'h41, 9'h000);   // column past the row, dropped
    send_item(OP_WRITE, 1'b1, 5'd31, 8'h41, 9'h1ff);   // dropped too
    send_item(OP_WRITE, 1'b0, 5'd15, 8'h7e, 9'h000);
    send_item(OP_READ,  1'b0, 5'd0,  8'h00, 9'h002);
    send_item(OP_READ,  1'b0, 5'd0,  8'h00, 9'h082);
    send_item(OP_READ,  1'b0, 5'd0,  8'h00, 9'h00f);
    send_item(OP_READ,  1'b0, 5'd0,  8'h00, 9'h08f);
    send_item(OP_READ,  1'b0, 5'd0,  8'h00, 9'h014);
    send_item(OP_READ,  1'b0, 5'd0,  8'h00, 9'h098);
    send_item(OP_READ,  1'b0, 5'd0,  8'h00, 9'h17b);
    send_item(OP_READ,  1'b0, 5'd0,  8'h00, 9'h1ff);
    send_item(OP_READ,  1'b0, 5'd0,  8'h00, 9'h105);   // row 1 col 0 still space
    send_item(OP_READ,  1'b0, 5'd0,  8'h00, 9'h07f);
    send_item(OP_NONE,  1'b1, 5'd5,  8'h41, 9'h0aa);   // no effect, no byte
    send_item(OP_CLEAR, 1'b1, 5'd31, 8'hff, 9'h1ff);
    send_item(OP_READ,  1'b0, 5'd0,  8'h00, 9'h002);
    send_item(OP_READ,  1'b0, 5'd0,  8'h00, 9'h17b);
    pause_input();
  endtask

  task automatic test_random_mix(int count);
    src_idle_on  = 1;
    sink_idle_on = 1;
    repeat (count) send_random_item();
    pause_input();
  endtask

  // receiver holds off while reads keep coming, so the input side backs up
  task automatic test_backpressure();
    src_idle_on  = 0;
    sink_idle_on = 0;
    hold_request = LONG_HOLD;
    repeat (24) send_item(OP_READ, 1'($urandom), 5'($urandom), 8'($urandom), 9'($urandom));
    pause_input();
  endtask

  task automatic test_steady_stream(int count);
    src_idle_on  = 0;
    sink_idle_on = 0;
    repeat (count) send_random_item();
    pause_input();
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    opcode       = OP_WRITE;
    row          = 1'b0;
    col          = 5'd0;
    char_code    = 8'h00;
    byte_address = 9'h000;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_mix(750);
    test_backpressure();
    test_steady_stream(420);

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      $error("bitmap_byte: %0d reads left unanswered", pending_bytes.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("text_mode_character_generator_core: match");
    end else begin
      $display("text_mode_character_generator_core: mismatch");
    end
    $finish;
  end

endmodule
